### design/smsp_pkg.sv
`timescale 1ns / 1ps

package smsp_pkg;

	localparam int KEY_W = 64;

	typedef logic [1:0] action_t;
	typedef logic [1:0] status_t;
	typedef logic signed [KEY_W-1:0] key_t;

	localparam action_t ACT_SUCC   = 2'd0;
	localparam action_t ACT_PRED   = 2'd1;
	localparam action_t ACT_INSERT = 2'd2;
	localparam action_t ACT_ERASE  = 2'd3;

	localparam status_t ST_OK     = 2'd0;
	localparam status_t ST_NONE   = 2'd1;
	localparam status_t ST_FULL   = 2'd2;
	localparam status_t ST_ABSENT = 2'd3;

	// Commands broadcast from the sequencer to every cell of the row.
	typedef struct packed {
		logic cmp;
		logic ins;
		logic del;
		logic succ;
		logic pred;
	} cell_ctrl_t;

endpackage

### design/smsp_req_if.sv
`timescale 1ns / 1ps

interface smsp_req_if;
	import smsp_pkg::*;

	logic valid;
	logic ready;
	action_t action;
	key_t key;

	modport source (output valid, output action, output key, input ready);
	modport sink (input valid, input action, input key, output ready);

endinterface

### design/smsp_rsp_if.sv
`timescale 1ns / 1ps

interface smsp_rsp_if;
	import smsp_pkg::*;

	logic valid;
	logic ready;
	key_t answer;
	status_t status;

	modport source (output valid, output answer, output status, input ready);
	modport sink (input valid, input answer, input status, output ready);

endinterface

### design/smsp_cell.sv
`timescale 1ns / 1ps

module smsp_cell (
	input  logic                clk,
	input  smsp_pkg::cell_ctrl_t ctrl,
	input  smsp_pkg::key_t      key_in,
	input  logic                occ,
	input  logic                left_le,
	input  logic                left_gt,
	input  smsp_pkg::key_t      left_key,
	input  logic                right_lt,
	input  smsp_pkg::key_t      right_key,
	output smsp_pkg::key_t      key_q,
	output logic                lt_q,
	output logic                gt_q,
	output logic                le,
	output logic                eq,
	output smsp_pkg::key_t      pick_key
);
	import smsp_pkg::*;

	logic occ_q;
	logic pick;

	assign le = occ_q && !gt_q;
	assign eq = occ_q && !gt_q && !lt_q;

	// A successor sits at the first cell above the key, a predecessor at the
	// last cell below it.
	assign pick = (ctrl.succ && gt_q && !left_gt) || (ctrl.pred && lt_q && !right_lt);
	assign pick_key = pick ? key_q : '0;

	always_ff @(posedge clk) begin
		if (ctrl.cmp) begin
			occ_q <= occ;
			lt_q  <= occ && (key_q < key_in);
			gt_q  <= occ && (key_q > key_in);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins && !le) begin
			key_q <= left_le ? key_in : left_key;
		end else if (ctrl.del && !lt_q) begin
			key_q <= right_key;
		end
	end

endmodule

### design/sorted_multiset_succ_pred_unit.sv
`timescale 1ns / 1ps

// Sorted multiset of signed 64-bit keys with successor and predecessor queries.
// Requests arrive on req (action, key); every request gives exactly one
// response on rsp (answer, status). Action 0 asks for the smallest stored key
// above the key, 1 for the largest below it, 2 inserts a copy, 3 erases one.
// The keys live in a row of CAPACITY cells, one key per cell, kept in order.
// A request is registered at its transfer, all cells compare against it in
// the next cycle, and in the update state that follows, once the output
// register is free, an insert or erase shifts the cells right or left by
// one place while the response is written to the output register. A new
// request is taken once the previous one has reached the output register.
// If the receiver holds rsp.ready low, the next request is still taken and
// compared, then waits in its update cycle until the output register frees.
// Reset empties the store and drops any pending response; the cells need no
// clearing since only the first key-count cells are ever used.
module sorted_multiset_succ_pred_unit #(
	parameter int CAPACITY = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	smsp_req_if.sink   req,
	smsp_rsp_if.source rsp
);
	import smsp_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_UPD  = 3'b100
	} state_t;

	state_t state_q;
	action_t action_s1;
	key_t key_s1;
	logic [CNT_W-1:0] count_q;
	key_t answer_q;
	status_t status_q;
	logic out_valid_q;

	cell_ctrl_t ctrl;
	logic go;
	logic full;
	logic found;
	logic any_gt;
	logic any_lt;
	key_t pick_or;

	key_t keys [CAPACITY];
	key_t picks [CAPACITY];
	logic [CAPACITY-1:0] lt_v;
	logic [CAPACITY-1:0] gt_v;
	logic [CAPACITY-1:0] le_v;
	logic [CAPACITY-1:0] eq_v;

	assign req.ready = (state_q == S_IDLE);
	assign go = (state_q == S_UPD) && (!out_valid_q || rsp.ready);
	assign full = (count_q == CNT_W'(CAPACITY));
	assign found = |eq_v;
	assign any_gt = |gt_v;
	assign any_lt = |lt_v;

	always_comb begin
		ctrl.cmp  = (state_q == S_CMP);
		ctrl.ins  = go && (action_s1 == ACT_INSERT) && !full;
		ctrl.del  = go && (action_s1 == ACT_ERASE) && found;
		ctrl.succ = (action_s1 == ACT_SUCC);
		ctrl.pred = (action_s1 == ACT_PRED);
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic occ;
		logic left_le;
		logic left_gt;
		key_t left_key;
		logic right_lt;
		key_t right_key;

		assign occ = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_first
			assign left_le  = 1'b1;
			assign left_gt  = 1'b0;
			assign left_key = '0;
		end else begin : g_mid
			assign left_le  = le_v[i-1];
			assign left_gt  = gt_v[i-1];
			assign left_key = keys[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_lt  = 1'b0;
			assign right_key = '0;
		end else begin : g_inner
			assign right_lt  = lt_v[i+1];
			assign right_key = keys[i+1];
		end

		smsp_cell u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.key_in   (key_s1),
			.occ      (occ),
			.left_le  (left_le),
			.left_gt  (left_gt),
			.left_key (left_key),
			.right_lt (right_lt),
			.right_key(right_key),
			.key_q    (keys[i]),
			.lt_q     (lt_v[i]),
			.gt_q     (gt_v[i]),
			.le       (le_v[i]),
			.eq       (eq_v[i]),
			.pick_key (picks[i])
		);
	end

	// At most one cell offers a key, so a plain OR collects the answer.
	always_comb begin
		pick_or = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			pick_or = pick_or | picks[i];
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			key_s1    <= req.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q <= S_UPD;
				end
				S_UPD: begin
					if (go) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (ctrl.ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (ctrl.del) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			answer_q <= '0;
			status_q <= ST_OK;
			case (action_s1)
				ACT_SUCC: begin
					if (any_gt) begin
						answer_q <= pick_or;
					end else begin
						status_q <= ST_NONE;
					end
				end
				ACT_PRED: begin
					if (any_lt) begin
						answer_q <= pick_or;
					end else begin
						status_q <= ST_NONE;
					end
				end
				ACT_INSERT: begin
					if (full) begin
						status_q <= ST_FULL;
					end
				end
				default: begin
					if (!found) begin
						status_q <= ST_ABSENT;
					end
				end
			endcase
		end
	end

	assign rsp.valid  = out_valid_q;
	assign rsp.answer = answer_q;
	assign rsp.status = status_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("key count above capacity");

	a_full_insert_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		go && (action_s1 == ACT_INSERT) && full |=> count_q == $past(count_q))
		else $error("insert into a full store changed the count");

	a_update_gives_response: assert property (@(posedge clk) disable iff (!arst_n)
		go |=> rsp.valid)
		else $error("update cycle produced no response");

	a_query_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) && (action_s1 == ACT_SUCC || action_s1 == ACT_PRED)
		|=> count_q == $past(count_q))
		else $error("query changed the key count");
`endif

endmodule

### tb/sv/sorted_multiset_succ_pred_unit_test.sv
`timescale 1ns / 1ps

module sorted_multiset_succ_pred_unit_test;
	import smsp_pkg::*;

	localparam int DEPTH = 64;
	localparam int QUIET_LIMIT = 2000;
	localparam int ITEMS_PER_PHASE = 206;
	localparam int SEND_IDLE [4] = '{0, 80, 0, 15};
	localparam int RECV_STALL [4] = '{0, 0, 80, 15};

	localparam key_t KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
	localparam key_t KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};
	localparam key_t ZERO = '0;

	typedef struct packed {
		key_t    answer;
		status_t status;
	} outcome_t;

	typedef struct packed {
		action_t  act;
		key_t     key;
		logic     fixed;
		outcome_t want;
	} plan_row_t;

	// Rows with fixed set carry their result; the others take the predicted one.
	localparam int PLAN_LEN = 24;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ACT_SUCC,   ZERO,     1'b1, '{ZERO, ST_NONE}},
		'{ACT_PRED,   ZERO,     1'b1, '{ZERO, ST_NONE}},
		'{ACT_ERASE,  64'sd5,   1'b1, '{ZERO, ST_ABSENT}},
		'{ACT_INSERT, KEY_MIN,  1'b1, '{ZERO, ST_OK}},
		'{ACT_INSERT, KEY_MAX,  1'b1, '{ZERO, ST_OK}},
		'{ACT_INSERT, ZERO,     1'b1, '{ZERO, ST_OK}},
		'{ACT_INSERT, ZERO,     1'b1, '{ZERO, ST_OK}},
		'{ACT_INSERT, -64'sd3,  1'b0, '{ZERO, ST_OK}},
		'{ACT_SUCC,   KEY_MIN,  1'b0, '{ZERO, ST_OK}},
		'{ACT_PRED,   KEY_MAX,  1'b0, '{ZERO, ST_OK}},
		'{ACT_SUCC,   ZERO,     1'b0, '{ZERO, ST_OK}},
		'{ACT_PRED,   ZERO,     1'b0, '{ZERO, ST_OK}},
		'{ACT_SUCC,   KEY_MAX,  1'b1, '{ZERO, ST_NONE}},
		'{ACT_PRED,   KEY_MIN,  1'b1, '{ZERO, ST_NONE}},
		'{ACT_ERASE,  ZERO,     1'b0, '{ZERO, ST_OK}},
		'{ACT_SUCC,   -64'sd1,  1'b0, '{ZERO, ST_OK}},
		'{ACT_ERASE,  64'sd7,   1'b1, '{ZERO, ST_ABSENT}},
		'{ACT_ERASE,  KEY_MIN,  1'b0, '{ZERO, ST_OK}},
		'{ACT_ERASE,  KEY_MAX,  1'b0, '{ZERO, ST_OK}},
		'{ACT_ERASE,  ZERO,     1'b0, '{ZERO, ST_OK}},
		'{ACT_ERASE,  -64'sd3,  1'b0, '{ZERO, ST_OK}},
		'{ACT_PRED,   KEY_MAX,  1'b1, '{ZERO, ST_NONE}},
		'{ACT_SUCC,   KEY_MIN,  1'b1, '{ZERO, ST_NONE}},
		'{ACT_ERASE,  ZERO,     1'b1, '{ZERO, ST_ABSENT}}
	};

	logic clk;
	logic arst_n;

	smsp_req_if req();
	smsp_rsp_if rsp();

	sorted_multiset_succ_pred_unit #(
		.CAPACITY(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req.sink),
		.rsp(rsp.source)
	);

	key_t     held_keys [$];
	outcome_t awaited [$];
	int       errors = 0;
	int       requests = 0;
	int       peak_fill = 0;
	int       send_idle_pct = 0;
	int       stall_pct = 0;
	int       status_seen [4] = '{0, 0, 0, 0};

	function automatic int first_above(key_t k);
		foreach (held_keys[i])
			if (held_keys[i] > k)
				return i;
		return held_keys.size();
	endfunction

	function automatic int first_not_below(key_t k);
		foreach (held_keys[i])
			if (held_keys[i] >= k)
				return i;
		return held_keys.size();
	endfunction

	function automatic outcome_t apply_request(action_t act, key_t k);
		outcome_t res;
		int pos;
		res.answer = '0;
		res.status = ST_OK;
		case (act)
			ACT_SUCC: begin
				pos = first_above(k);
				if (pos < held_keys.size())
					res.answer = held_keys[pos];
				else
					res.status = ST_NONE;
			end
			ACT_PRED: begin
				pos = first_not_below(k);
				if (pos > 0)
					res.answer = held_keys[pos-1];
				else
					res.status = ST_NONE;
			end
			ACT_INSERT: begin
				if (held_keys.size() >= DEPTH)
					res.status = ST_FULL;
				else
					held_keys.insert(first_above(k), k);
			end
			default: begin
				pos = first_not_below(k);
				if (pos < held_keys.size() && held_keys[pos] == k)
					held_keys.delete(pos);
				else
					res.status = ST_ABSENT;
			end
		endcase
		if (held_keys.size() > peak_fill)
			peak_fill = held_keys.size();
		return res;
	endfunction

	// Keys lean toward stored values and a narrow band around zero so that
	// duplicates, hits and near misses are common.
	function automatic key_t pick_key(bit exact);
		int r;
		key_t k;
		r = $urandom_range(9);
		if (held_keys.size() != 0 && (exact || r >= 7)) begin
			k = held_keys[$urandom_range(held_keys.size() - 1)];
			if (!exact)
				k = k + key_t'($signed($urandom_range(2)) - 1);
			return k;
		end
		if (r < 4)
			return key_t'($signed($urandom_range(16)) - 8);
		if (r < 6)
			return {$urandom, $urandom};
		return r[0] ? KEY_MAX - $urandom_range(1) : KEY_MIN + $urandom_range(1);
	endfunction

	task automatic send(action_t act, key_t k, logic fixed, outcome_t want);
		outcome_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.key <= k;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		got = apply_request(act, k);
		awaited.insert(awaited.size(), fixed ? want : got);
		requests++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		rsp.ready = 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	initial begin
		int quiet;
		outcome_t want;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				quiet = 0;
			else
				quiet++;
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					errors++;
					$display("%0t: response with none expected, answer %0d status %0d",
						$time, rsp.answer, rsp.status);
				end else begin
					want = awaited.pop_front();
					status_seen[want.status]++;
					if (rsp.answer !== want.answer) begin
						errors++;
						$display("%0t: answer expected %0d, actual %0d",
							$time, want.answer, rsp.answer);
					end
					if (rsp.status !== want.status) begin
						errors++;
						$display("%0t: status expected %0d, actual %0d",
							$time, want.status, rsp.status);
					end
				end
			end
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	initial begin
		bit filling;
		int r;
		action_t act;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.action = ACT_SUCC;
		req.key = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (PLAN[i])
			send(PLAN[i].act, PLAN[i].key, PLAN[i].fixed, PLAN[i].want);

		// Alternate between filling the store up to the full case and
		// draining it back to empty.
		filling = 1'b1;
		for (int phase = 0; phase < 4; phase++) begin
			send_idle_pct = SEND_IDLE[phase];
			stall_pct = RECV_STALL[phase];
			req.valid <= 1'b0;
			@(posedge clk);
			while (awaited.size() != 0)
				@(posedge clk);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if (filling && held_keys.size() == DEPTH && $urandom_range(3) == 0)
					filling = 1'b0;
				else if (!filling && held_keys.size() == 0)
					filling = 1'b1;
				r = $urandom_range(99);
				if (r < (filling ? 55 : 15))
					act = ACT_INSERT;
				else if (r < (filling ? 70 : 60))
					act = ACT_ERASE;
				else if (r < (filling ? 85 : 80))
					act = ACT_SUCC;
				else
					act = ACT_PRED;
				send(act, pick_key(act == ACT_ERASE && $urandom_range(3) != 0), 1'b0, '0);
			end
		end

		req.valid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d requests over four flow-control phases, peak fill %0d of %0d.",
			requests, peak_fill, DEPTH);
		$display("Results by status: ok %0d, no neighbor %0d, store full %0d, key absent %0d.",
			status_seen[ST_OK], status_seen[ST_NONE], status_seen[ST_FULL],
			status_seen[ST_ABSENT]);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

### sorted_multiset_succ_pred_unit.f
design/smsp_pkg.sv
design/smsp_req_if.sv
design/smsp_rsp_if.sv
design/smsp_cell.sv
design/sorted_multiset_succ_pred_unit.sv
tb/sv/sorted_multiset_succ_pred_unit_test.sv
